// ----- rtl/mrk_pkg.sv -----
package mrk_pkg;

    localparam int DATA_W   = 32;
    localparam int STEP_W   = 25;
    localparam int CFG_AW   = 3;
    localparam int NUM_VARS = 5;
    localparam int PC_W     = 6;
    localparam int SLOPE_LEN = 16;
    localparam logic [PC_W-1:0] PC_MID    = 6'd16;
    localparam logic [PC_W-1:0] PC_SLOPE2 = 6'd31;
    localparam logic [PC_W-1:0] PC_LAST   = 6'd56;

    typedef enum logic [CFG_AW-1:0] {
        CFG_GAIN_A1   = 3'd0,
        CFG_GAIN_B1   = 3'd1,
        CFG_TARGET_G1 = 3'd2,
        CFG_GAIN_A2   = 3'd3,
        CFG_GAIN_B2   = 3'd4,
        CFG_TARGET_G2 = 3'd5,
        CFG_STEP_SIZE = 3'd6
    } cfg_idx_t;

    localparam logic FUNC_LOAD = 1'b0;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL
    } op_t;

    // Operand and destination codes of the working register set.
    typedef enum logic [4:0] {
        SRC_W0, SRC_W1, SRC_W2, SRC_W3, SRC_W4,
        SRC_Z0, SRC_Z1, SRC_Z2, SRC_Z3, SRC_Z4,
        SRC_D1, SRC_D3, SRC_D4,
        SRC_T0, SRC_T1, SRC_T2, SRC_K,
        SRC_ONE, SRC_HALF, SRC_ZERO,
        SRC_A1, SRC_B1, SRC_G1, SRC_A2, SRC_B2, SRC_G2, SRC_H
    } src_t;

    typedef struct packed {
        op_t  op;
        src_t src_a;
        src_t src_b;
        src_t dst;
    } uop_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_MULW,
        ST_OUT
    } state_t;

    typedef struct packed {
        uop_t uop;
        logic wr_en;
        logic mul_load;
        logic item_load;
        logic item_step;
        logic out_load;
    } ctrl_t;

    function automatic uop_t mk(op_t op, src_t a, src_t b, src_t d);
        uop_t u;
        u.op    = op;
        u.src_a = a;
        u.src_b = b;
        u.dst   = d;
        return u;
    endfunction

    // One derivative evaluation on the working vector W.
    function automatic uop_t slope_op(logic [3:0] i);
        uop_t u;
        case (i)
            4'd0:    u = mk(OP_SUB, SRC_G1,   SRC_W0, SRC_T0);
            4'd1:    u = mk(OP_MUL, SRC_B1,   SRC_T0, SRC_T0);
            4'd2:    u = mk(OP_SUB, SRC_T0,   SRC_W1, SRC_T0);
            4'd3:    u = mk(OP_MUL, SRC_A1,   SRC_T0, SRC_T0);
            4'd4:    u = mk(OP_ADD, SRC_T0,   SRC_W4, SRC_D1);
            4'd5:    u = mk(OP_MUL, SRC_W4,   SRC_W4, SRC_T1);
            4'd6:    u = mk(OP_SUB, SRC_ONE,  SRC_T1, SRC_T1);
            4'd7:    u = mk(OP_MUL, SRC_W4,   SRC_T1, SRC_T1);
            4'd8:    u = mk(OP_ADD, SRC_T1,   SRC_T1, SRC_T2);
            4'd9:    u = mk(OP_ADD, SRC_T2,   SRC_T1, SRC_T1);
            4'd10:   u = mk(OP_SUB, SRC_G2,   SRC_W2, SRC_T0);
            4'd11:   u = mk(OP_MUL, SRC_B2,   SRC_T0, SRC_T0);
            4'd12:   u = mk(OP_SUB, SRC_T0,   SRC_W3, SRC_T0);
            4'd13:   u = mk(OP_MUL, SRC_A2,   SRC_T0, SRC_T0);
            4'd14:   u = mk(OP_ADD, SRC_T0,   SRC_T1, SRC_D3);
            4'd15:   u = mk(OP_SUB, SRC_ZERO, SRC_W4, SRC_D4);
            default: u = mk(OP_ADD, SRC_ZERO, SRC_ZERO, SRC_K);
        endcase
        return u;
    endfunction

    // Whole midpoint step: slope, half step into W, slope, full step into Z.
    function automatic uop_t prog_rom(logic [PC_W-1:0] pc);
        uop_t u;
        logic [PC_W-1:0] rel;
        rel = pc - PC_SLOPE2;
        if (pc < PC_MID) begin
            u = slope_op(pc[3:0]);
        end else if (pc >= PC_SLOPE2 && rel < PC_W'(SLOPE_LEN)) begin
            u = slope_op(rel[3:0]);
        end else begin
            case (pc)
                6'd16:   u = mk(OP_MUL, SRC_H,  SRC_W1,   SRC_K);
                6'd17:   u = mk(OP_MUL, SRC_K,  SRC_HALF, SRC_K);
                6'd18:   u = mk(OP_ADD, SRC_Z0, SRC_K,    SRC_W0);
                6'd19:   u = mk(OP_MUL, SRC_H,  SRC_D1,   SRC_K);
                6'd20:   u = mk(OP_MUL, SRC_K,  SRC_HALF, SRC_K);
                6'd21:   u = mk(OP_ADD, SRC_Z1, SRC_K,    SRC_W1);
                6'd22:   u = mk(OP_MUL, SRC_H,  SRC_W3,   SRC_K);
                6'd23:   u = mk(OP_MUL, SRC_K,  SRC_HALF, SRC_K);
                6'd24:   u = mk(OP_ADD, SRC_Z2, SRC_K,    SRC_W2);
                6'd25:   u = mk(OP_MUL, SRC_H,  SRC_D3,   SRC_K);
                6'd26:   u = mk(OP_MUL, SRC_K,  SRC_HALF, SRC_K);
                6'd27:   u = mk(OP_ADD, SRC_Z3, SRC_K,    SRC_W3);
                6'd28:   u = mk(OP_MUL, SRC_H,  SRC_D4,   SRC_K);
                6'd29:   u = mk(OP_MUL, SRC_K,  SRC_HALF, SRC_K);
                6'd30:   u = mk(OP_ADD, SRC_Z4, SRC_K,    SRC_W4);
                6'd47:   u = mk(OP_MUL, SRC_H,  SRC_W1,   SRC_K);
                6'd48:   u = mk(OP_ADD, SRC_Z0, SRC_K,    SRC_Z0);
                6'd49:   u = mk(OP_MUL, SRC_H,  SRC_D1,   SRC_K);
                6'd50:   u = mk(OP_ADD, SRC_Z1, SRC_K,    SRC_Z1);
                6'd51:   u = mk(OP_MUL, SRC_H,  SRC_W3,   SRC_K);
                6'd52:   u = mk(OP_ADD, SRC_Z2, SRC_K,    SRC_Z2);
                6'd53:   u = mk(OP_MUL, SRC_H,  SRC_D3,   SRC_K);
                6'd54:   u = mk(OP_ADD, SRC_Z3, SRC_K,    SRC_Z3);
                6'd55:   u = mk(OP_MUL, SRC_H,  SRC_D4,   SRC_K);
                6'd56:   u = mk(OP_ADD, SRC_Z4, SRC_K,    SRC_Z4);
                default: u = mk(OP_ADD, SRC_ZERO, SRC_ZERO, SRC_K);
            endcase
        end
        return u;
    endfunction

endpackage

// ----- rtl/mrk_alu.sv -----
module mrk_alu #(
    parameter int FRAC_BITS = 24
) (
    input  logic                                 aclk,
    input  mrk_pkg::op_t                         op,
    input  logic signed [mrk_pkg::DATA_W-1:0]    a,
    input  logic signed [mrk_pkg::DATA_W-1:0]    b,
    input  logic                                 mul_load,
    output logic signed [mrk_pkg::DATA_W-1:0]    result,
    output logic                                 sat
);

    localparam int PW = 2 * mrk_pkg::DATA_W;
    localparam int WW = PW + 1;
    localparam logic signed [WW-1:0] HALF_W = WW'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [WW-1:0] MAX_W  = (WW'(1) <<< (mrk_pkg::DATA_W - 1)) - WW'(1);
    localparam logic signed [WW-1:0] MIN_W  = -(WW'(1) <<< (mrk_pkg::DATA_W - 1));

    logic signed [PW-1:0]             prod_reg;
    logic signed [WW-1:0]             rnd_sum;
    logic signed [WW-1:0]             mul_wide;
    logic signed [mrk_pkg::DATA_W:0]  add_sum;
    logic signed [WW-1:0]             wide;

    // The product is registered; rounding and clamping happen the cycle after.
    always_ff @(posedge aclk) begin
        if (mul_load) begin
            prod_reg <= a * b;
        end
    end

    always_comb begin
        rnd_sum  = {prod_reg[PW-1], prod_reg} + HALF_W;
        mul_wide = rnd_sum >>> FRAC_BITS;
        if (op == mrk_pkg::OP_SUB) begin
            add_sum = {a[mrk_pkg::DATA_W-1], a} - {b[mrk_pkg::DATA_W-1], b};
        end else begin
            add_sum = {a[mrk_pkg::DATA_W-1], a} + {b[mrk_pkg::DATA_W-1], b};
        end
        if (op == mrk_pkg::OP_MUL) begin
            wide = mul_wide;
        end else begin
            wide = WW'(add_sum);
        end
        if (wide > MAX_W) begin
            result = MAX_W[mrk_pkg::DATA_W-1:0];
            sat    = 1'b1;
        end else if (wide < MIN_W) begin
            result = MIN_W[mrk_pkg::DATA_W-1:0];
            sat    = 1'b1;
        end else begin
            result = wide[mrk_pkg::DATA_W-1:0];
            sat    = 1'b0;
        end
    end

endmodule

// ----- rtl/mrk_seq.sv -----
module mrk_seq (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_fire,
    input  logic            in_func,
    input  logic            out_free,
    output logic            in_ready,
    output mrk_pkg::ctrl_t  ctrl
);

    mrk_pkg::state_t              state_reg, state_next;
    logic [mrk_pkg::PC_W-1:0]     pc_reg, pc_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mrk_pkg::ST_IDLE;
            pc_reg    <= '0;
        end else begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        pc_next        = pc_reg;
        in_ready       = 1'b0;
        ctrl           = '0;
        ctrl.uop       = mrk_pkg::prog_rom(pc_reg);
        case (state_reg)
            mrk_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                if (in_fire) begin
                    if (in_func == mrk_pkg::FUNC_LOAD) begin
                        ctrl.item_load = 1'b1;
                        state_next     = mrk_pkg::ST_OUT;
                    end else begin
                        ctrl.item_step = 1'b1;
                        pc_next        = '0;
                        state_next     = mrk_pkg::ST_EXEC;
                    end
                end
            end
            mrk_pkg::ST_EXEC: begin
                if (ctrl.uop.op == mrk_pkg::OP_MUL) begin
                    ctrl.mul_load = 1'b1;
                    state_next    = mrk_pkg::ST_MULW;
                end else begin
                    ctrl.wr_en = 1'b1;
                    if (pc_reg == mrk_pkg::PC_LAST) begin
                        state_next = mrk_pkg::ST_OUT;
                    end else begin
                        pc_next = pc_reg + 1'b1;
                    end
                end
            end
            mrk_pkg::ST_MULW: begin
                ctrl.wr_en = 1'b1;
                if (pc_reg == mrk_pkg::PC_LAST) begin
                    state_next = mrk_pkg::ST_OUT;
                end else begin
                    pc_next    = pc_reg + 1'b1;
                    state_next = mrk_pkg::ST_EXEC;
                end
            end
            mrk_pkg::ST_OUT: begin
                if (out_free) begin
                    ctrl.out_load = 1'b1;
                    state_next    = mrk_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = mrk_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/midpoint_rk2_coupled_tracker_core.sv -----
// Load request: the inputs are loaded into the state on acceptance, and the result is
// registered once the output is free. Step request: 27 multiplies and 30 adds on the
// shared multiply/add unit, each multiply with a wait state for its product, then the
// result is registered once the output is free; no new request is taken before that.
// Reset (synchronous, active low) clears the state to zero with the drive at 1.0
// and restores the default gains, targets and step size.
module midpoint_rk2_coupled_tracker_core #(
    parameter int FRAC_BITS = 24
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [95:0]                         s_tdata,   // start_y1, start_y2, start_x
    input  logic [0:0]                          s_tuser,   // func
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [159:0]                        m_tdata,   // y1_out, y1_rate_out, y2_out,
                                                           // y2_rate_out, drive_out
    output logic [0:0]                          m_tuser,   // saturated
    input  logic                                cfg_we,
    input  logic [mrk_pkg::CFG_AW-1:0]          cfg_addr,
    input  logic [mrk_pkg::DATA_W-1:0]          cfg_wdata
);

    localparam int DW = mrk_pkg::DATA_W;
    localparam logic signed [DW-1:0] ONE_FX   = DW'(64'sd1 <<< FRAC_BITS);
    localparam logic signed [DW-1:0] TWO_FX   = DW'(64'sd2 <<< FRAC_BITS);
    localparam logic signed [DW-1:0] QTR_FX   = DW'(64'sd1 <<< (FRAC_BITS - 2));
    localparam logic signed [DW-1:0] HALF_FX  = DW'(64'sd1 <<< (FRAC_BITS - 1));
    localparam logic [mrk_pkg::STEP_W-1:0] STEP_RST =
        mrk_pkg::STEP_W'((64'd1 << FRAC_BITS) / 1000);

    logic signed [DW-1:0]           gain_a1_reg, gain_b1_reg, target_g1_reg;
    logic signed [DW-1:0]           gain_a2_reg, gain_b2_reg, target_g2_reg;
    logic [mrk_pkg::STEP_W-1:0]     step_size_reg;

    logic signed [DW-1:0]           z_reg [mrk_pkg::NUM_VARS];
    logic signed [DW-1:0]           w_reg [mrk_pkg::NUM_VARS];
    logic signed [DW-1:0]           d1_reg, d3_reg, d4_reg;
    logic signed [DW-1:0]           t0_reg, t1_reg, t2_reg, k_reg;
    logic                           sat_reg;

    logic                           m_tvalid_reg;
    logic [159:0]                   m_tdata_reg;
    logic                           m_tuser_reg;

    logic                           in_fire;
    logic                           out_free;
    mrk_pkg::ctrl_t                 ctrl;
    logic signed [DW-1:0]           opnd_a, opnd_b, alu_result;
    logic                           alu_sat;

    function automatic logic signed [DW-1:0] pick(mrk_pkg::src_t s);
        logic signed [DW-1:0] v;
        case (s)
            mrk_pkg::SRC_W0:   v = w_reg[0];
            mrk_pkg::SRC_W1:   v = w_reg[1];
            mrk_pkg::SRC_W2:   v = w_reg[2];
            mrk_pkg::SRC_W3:   v = w_reg[3];
            mrk_pkg::SRC_W4:   v = w_reg[4];
            mrk_pkg::SRC_Z0:   v = z_reg[0];
            mrk_pkg::SRC_Z1:   v = z_reg[1];
            mrk_pkg::SRC_Z2:   v = z_reg[2];
            mrk_pkg::SRC_Z3:   v = z_reg[3];
            mrk_pkg::SRC_Z4:   v = z_reg[4];
            mrk_pkg::SRC_D1:   v = d1_reg;
            mrk_pkg::SRC_D3:   v = d3_reg;
            mrk_pkg::SRC_D4:   v = d4_reg;
            mrk_pkg::SRC_T0:   v = t0_reg;
            mrk_pkg::SRC_T1:   v = t1_reg;
            mrk_pkg::SRC_T2:   v = t2_reg;
            mrk_pkg::SRC_K:    v = k_reg;
            mrk_pkg::SRC_ONE:  v = ONE_FX;
            mrk_pkg::SRC_HALF: v = HALF_FX;
            mrk_pkg::SRC_A1:   v = gain_a1_reg;
            mrk_pkg::SRC_B1:   v = gain_b1_reg;
            mrk_pkg::SRC_G1:   v = target_g1_reg;
            mrk_pkg::SRC_A2:   v = gain_a2_reg;
            mrk_pkg::SRC_B2:   v = gain_b2_reg;
            mrk_pkg::SRC_G2:   v = target_g2_reg;
            mrk_pkg::SRC_H:    v = DW'(step_size_reg);
            default:           v = '0;
        endcase
        return v;
    endfunction

    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        opnd_a = pick(ctrl.uop.src_a);
        opnd_b = pick(ctrl.uop.src_b);
    end

    mrk_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_fire  (in_fire),
        .in_func  (s_tuser[0]),
        .out_free (out_free),
        .in_ready (s_tready),
        .ctrl     (ctrl)
    );

    mrk_alu #(
        .FRAC_BITS (FRAC_BITS)
    ) u_alu (
        .aclk     (aclk),
        .op       (ctrl.uop.op),
        .a        (opnd_a),
        .b        (opnd_b),
        .mul_load (ctrl.mul_load),
        .result   (alu_result),
        .sat      (alu_sat)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_a1_reg   <= ONE_FX;
            gain_b1_reg   <= ONE_FX;
            target_g1_reg <= TWO_FX;
            gain_a2_reg   <= QTR_FX;
            gain_b2_reg   <= QTR_FX;
            target_g2_reg <= ONE_FX;
            step_size_reg <= STEP_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                mrk_pkg::CFG_GAIN_A1:   gain_a1_reg   <= cfg_wdata;
                mrk_pkg::CFG_GAIN_B1:   gain_b1_reg   <= cfg_wdata;
                mrk_pkg::CFG_TARGET_G1: target_g1_reg <= cfg_wdata;
                mrk_pkg::CFG_GAIN_A2:   gain_a2_reg   <= cfg_wdata;
                mrk_pkg::CFG_GAIN_B2:   gain_b2_reg   <= cfg_wdata;
                mrk_pkg::CFG_TARGET_G2: target_g2_reg <= cfg_wdata;
                mrk_pkg::CFG_STEP_SIZE: step_size_reg <= cfg_wdata[mrk_pkg::STEP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Tracker state: written by a load request or by the final update micro-ops.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            z_reg[0] <= '0;
            z_reg[1] <= '0;
            z_reg[2] <= '0;
            z_reg[3] <= '0;
            z_reg[4] <= ONE_FX;
            sat_reg  <= 1'b0;
        end else if (ctrl.item_load) begin
            z_reg[0] <= s_tdata[31:0];
            z_reg[1] <= '0;
            z_reg[2] <= s_tdata[63:32];
            z_reg[3] <= '0;
            z_reg[4] <= s_tdata[95:64];
            sat_reg  <= 1'b0;
        end else if (ctrl.item_step) begin
            sat_reg <= 1'b0;
        end else if (ctrl.wr_en) begin
            sat_reg <= sat_reg | alu_sat;
            case (ctrl.uop.dst)
                mrk_pkg::SRC_Z0: z_reg[0] <= alu_result;
                mrk_pkg::SRC_Z1: z_reg[1] <= alu_result;
                mrk_pkg::SRC_Z2: z_reg[2] <= alu_result;
                mrk_pkg::SRC_Z3: z_reg[3] <= alu_result;
                mrk_pkg::SRC_Z4: z_reg[4] <= alu_result;
                default: begin
                end
            endcase
        end
    end

    // Working registers; W starts as a copy of the state for the first slope.
    always_ff @(posedge aclk) begin
        if (ctrl.item_step) begin
            for (int i = 0; i < mrk_pkg::NUM_VARS; i++) begin
                w_reg[i] <= z_reg[i];
            end
        end else if (ctrl.wr_en) begin
            case (ctrl.uop.dst)
                mrk_pkg::SRC_W0: w_reg[0] <= alu_result;
                mrk_pkg::SRC_W1: w_reg[1] <= alu_result;
                mrk_pkg::SRC_W2: w_reg[2] <= alu_result;
                mrk_pkg::SRC_W3: w_reg[3] <= alu_result;
                mrk_pkg::SRC_W4: w_reg[4] <= alu_result;
                mrk_pkg::SRC_D1: d1_reg   <= alu_result;
                mrk_pkg::SRC_D3: d3_reg   <= alu_result;
                mrk_pkg::SRC_D4: d4_reg   <= alu_result;
                mrk_pkg::SRC_T0: t0_reg   <= alu_result;
                mrk_pkg::SRC_T1: t1_reg   <= alu_result;
                mrk_pkg::SRC_T2: t2_reg   <= alu_result;
                mrk_pkg::SRC_K:  k_reg    <= alu_result;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (ctrl.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.out_load) begin
            m_tdata_reg <= {z_reg[4], z_reg[3], z_reg[2], z_reg[1], z_reg[0]};
            m_tuser_reg <= sat_reg;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

endmodule

// ----- tb/tb_midpoint_rk2_coupled_tracker_core.sv -----
module tb_midpoint_rk2_coupled_tracker_core;
    timeunit 1ns;
    timeprecision 1ps;

    import mrk_pkg::*;

    typedef logic signed [31:0] fx_t;

    typedef struct packed {
        fx_t pos1;
        fx_t rate1;
        fx_t pos2;
        fx_t rate2;
        fx_t drive;
    } track_t;

    typedef struct packed {
        track_t st;
        logic   sat;
    } outcome_t;

    typedef enum logic { ROW_CFG, ROW_ITEM } row_kind_t;

    typedef struct {
        row_kind_t         kind;
        logic [CFG_AW-1:0] addr;
        logic [31:0]       wdata;
        logic              func;
        fx_t               y1;
        fx_t               y2;
        fx_t               x;
        bit                known;
        track_t            want;
    } row_t;

    localparam int FRAC           = 24;
    localparam int RANDOM_ITEMS   = 1050;
    localparam int HOLD_CYCLES    = 3000;
    localparam int DRAIN_CYCLES   = 200;
    localparam int CYCLE_LIMIT    = 600000;

    localparam logic              FUNC_STEP = 1'b1;
    localparam logic [CFG_AW-1:0] CFG_NONE  = 3'd7;

    localparam fx_t    FX_MAX     = 32'h7FFF_FFFF;
    localparam fx_t    FX_MIN     = 32'h8000_0000;
    localparam fx_t    FX_ZERO    = 32'h0000_0000;
    localparam fx_t    FX_ONE     = 32'h0100_0000;
    localparam fx_t    FX_HALF    = 32'h0080_0000;
    localparam fx_t    FX_QUARTER = 32'h0040_0000;
    localparam longint HALF_LSB   = 64'sd1 <<< (FRAC - 1);

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [95:0]         s_tdata;    // start_y1, start_y2, start_x
    logic [0:0]          s_tuser;    // func
    logic                m_tvalid;
    logic                m_tready;
    logic [159:0]        m_tdata;    // y1_out, y1_rate_out, y2_out, y2_rate_out, drive_out
    logic [0:0]          m_tuser;    // saturated
    logic                cfg_we;
    logic [CFG_AW-1:0]   cfg_addr;
    logic [DATA_W-1:0]   cfg_wdata;

    // Shadow copy of the tracker state and its registers.
    fx_t         gain_a1_q, gain_b1_q, goal_g1_q, gain_a2_q, gain_b2_q, goal_g2_q;
    logic [24:0] step_h_q;
    track_t      track_q;
    bit          sat_seen;

    outcome_t    pending_states[$];
    row_t        plan[$];
    int          mismatches;
    int          cycles;
    bit          no_idle;
    bit          hold_req;

    midpoint_rk2_coupled_tracker_core #(
        .FRAC_BITS (FRAC)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    function automatic fx_t sat32(longint v);
        if (v > 64'sd2147483647) begin
            sat_seen = 1'b1;
            return FX_MAX;
        end
        if (v < -64'sd2147483648) begin
            sat_seen = 1'b1;
            return FX_MIN;
        end
        return fx_t'(v);
    endfunction

    function automatic fx_t sat_add(fx_t a, fx_t b);
        return sat32(longint'(a) + longint'(b));
    endfunction

    function automatic fx_t sat_sub(fx_t a, fx_t b);
        return sat32(longint'(a) - longint'(b));
    endfunction

    function automatic fx_t sat_neg(fx_t a);
        return sat32(-longint'(a));
    endfunction

    // Rounds half towards plus infinity: the arithmetic shift is a floor.
    function automatic fx_t fx_mul(longint a, longint b);
        longint q;
        q = a * b + HALF_LSB;
        return sat32(q >>> FRAC);
    endfunction

    function automatic track_t slope_of(track_t z);
        track_t d;
        fx_t    t;
        fx_t    u;
        d.pos1  = z.rate1;
        t       = sat_sub(fx_mul(gain_b1_q, sat_sub(goal_g1_q, z.pos1)), z.rate1);
        d.rate1 = sat_add(fx_mul(gain_a1_q, t), z.drive);
        d.pos2  = z.rate2;
        u       = fx_mul(z.drive, sat_sub(FX_ONE, fx_mul(z.drive, z.drive)));
        u       = sat_add(sat_add(u, u), u);
        t       = sat_sub(fx_mul(gain_b2_q, sat_sub(goal_g2_q, z.pos2)), z.rate2);
        d.rate2 = sat_add(fx_mul(gain_a2_q, t), u);
        d.drive = sat_neg(z.drive);
        return d;
    endfunction

    function automatic fx_t half_step(fx_t zv, fx_t dv);
        return sat_add(zv, fx_mul(fx_mul(step_h_q, dv), HALF_LSB));
    endfunction

    function automatic fx_t full_step(fx_t zv, fx_t dv);
        return sat_add(zv, fx_mul(step_h_q, dv));
    endfunction

    function automatic outcome_t advance_tracker(logic func, fx_t y1, fx_t y2, fx_t x);
        track_t   d;
        track_t   mid;
        outcome_t res;
        sat_seen = 1'b0;
        if (func == FUNC_LOAD) begin
            track_q = {y1, FX_ZERO, y2, FX_ZERO, x};
        end else begin
            d         = slope_of(track_q);
            mid.pos1  = half_step(track_q.pos1,  d.pos1);
            mid.rate1 = half_step(track_q.rate1, d.rate1);
            mid.pos2  = half_step(track_q.pos2,  d.pos2);
            mid.rate2 = half_step(track_q.rate2, d.rate2);
            mid.drive = half_step(track_q.drive, d.drive);
            d         = slope_of(mid);
            track_q.pos1  = full_step(track_q.pos1,  d.pos1);
            track_q.rate1 = full_step(track_q.rate1, d.rate1);
            track_q.pos2  = full_step(track_q.pos2,  d.pos2);
            track_q.rate2 = full_step(track_q.rate2, d.rate2);
            track_q.drive = full_step(track_q.drive, d.drive);
        end
        res.st  = track_q;
        res.sat = sat_seen;
        return res;
    endfunction

    function automatic int pause_len();
        return no_idle ? 0 : $urandom_range(0, 10);
    endfunction

    function automatic fx_t draw_gain();
        case ($urandom_range(0, 9))
            0:       return FX_MAX;
            1:       return FX_MIN;
            2:       return $urandom;
            default: return $urandom_range(0, 1 << 27) - (1 << 26);
        endcase
    endfunction

    function automatic logic [31:0] draw_step();
        case ($urandom_range(0, 9))
            0:       return 32'hFFFF_FFFF;
            1:       return 32'd1;
            2:       return $urandom;
            default: return $urandom_range(1, 1 << 20);
        endcase
    endfunction

    function automatic fx_t draw_level();
        if ($urandom_range(0, 5) == 0)
            return $urandom;
        return $urandom_range(0, 1 << 26) - (1 << 25);
    endfunction

    task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatches++;
        $display("MISMATCH %s: got %h, expected %h", what, got, want);
    endtask

    task automatic write_reg(logic [CFG_AW-1:0] addr, logic [31:0] data);
        while (pending_states.size() != 0)
            @(negedge aclk);
        cfg_we    = 1'b1;
        cfg_addr  = addr;
        cfg_wdata = data;
        @(negedge aclk);
        cfg_we    = 1'b0;
        case (addr)
            CFG_GAIN_A1:   gain_a1_q = data;
            CFG_GAIN_B1:   gain_b1_q = data;
            CFG_TARGET_G1: goal_g1_q = data;
            CFG_GAIN_A2:   gain_a2_q = data;
            CFG_GAIN_B2:   gain_b2_q = data;
            CFG_TARGET_G2: goal_g2_q = data;
            CFG_STEP_SIZE: step_h_q  = data[STEP_W-1:0];
            default: ;
        endcase
    endtask

    // Entered just after a falling edge; leaves just after one with nothing offered.
    task automatic offer(logic func, fx_t y1, fx_t y2, fx_t x, bit known, track_t want);
        int       gap;
        outcome_t res;
        gap = pause_len();
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = func;
        s_tdata  = {x, y2, y1};
        do
            @(posedge aclk);
        while (!s_tready);
        res = advance_tracker(func, y1, y2, x);
        if (known) begin
            res.st  = want;
            res.sat = 1'b0;
        end
        pending_states = {pending_states, res};
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    task automatic plan_write(logic [CFG_AW-1:0] addr, logic [31:0] data);
        row_t r;
        r       = '{kind: ROW_CFG, default: '0};
        r.kind  = ROW_CFG;
        r.addr  = addr;
        r.wdata = data;
        plan    = {plan, r};
    endtask

    task automatic plan_item(logic func, fx_t y1, fx_t y2, fx_t x, bit known, track_t want);
        row_t r;
        r       = '{kind: ROW_ITEM, default: '0};
        r.kind  = ROW_ITEM;
        r.func  = func;
        r.y1    = y1;
        r.y2    = y2;
        r.x     = x;
        r.known = known;
        r.want  = want;
        plan    = {plan, r};
    endtask

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
            @(posedge aclk) cycles++;
        $display("midpoint_rk2_coupled_tracker_core regression: fail");
        $finish;
    end

    // Result side: random stalls, one long hold-off on request, and the checks.
    initial begin
        int       stall;
        outcome_t want;
        track_t   got;
        m_tready = 1'b0;
        wait (aresetn);
        @(negedge aclk);
        forever begin
            if (hold_req) begin
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_req = 1'b0;
            end
            stall = pause_len();
            if (stall > 0) begin
                m_tready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready = 1'b1;
            do
                @(posedge aclk);
            while (!m_tvalid);
            got.pos1  = m_tdata[31:0];
            got.rate1 = m_tdata[63:32];
            got.pos2  = m_tdata[95:64];
            got.rate2 = m_tdata[127:96];
            got.drive = m_tdata[159:128];
            if (pending_states.size() == 0) begin
                flag_mismatch("result with nothing outstanding", got.pos1, '0);
            end else begin
                want = pending_states.pop_front();
                if (got.pos1 !== want.st.pos1)
                    flag_mismatch("y1_out", got.pos1, want.st.pos1);
                if (got.rate1 !== want.st.rate1)
                    flag_mismatch("y1_rate_out", got.rate1, want.st.rate1);
                if (got.pos2 !== want.st.pos2)
                    flag_mismatch("y2_out", got.pos2, want.st.pos2);
                if (got.rate2 !== want.st.rate2)
                    flag_mismatch("y2_rate_out", got.rate2, want.st.rate2);
                if (got.drive !== want.st.drive)
                    flag_mismatch("drive_out", got.drive, want.st.drive);
                if (m_tuser[0] !== want.sat)
                    flag_mismatch("saturated", 32'(m_tuser[0]), 32'(want.sat));
            end
            @(negedge aclk);
        end
    end

    initial begin
        int  items_sent;
        int  phase;
        int  len;
        bit  is_load;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cfg_we    = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        no_idle   = 1'b0;
        hold_req  = 1'b0;
        mismatches = 0;

        gain_a1_q = FX_ONE;
        gain_b1_q = FX_ONE;
        goal_g1_q = 32'h0200_0000;
        gain_a2_q = FX_QUARTER;
        gain_b2_q = FX_QUARTER;
        goal_g2_q = FX_ONE;
        step_h_q  = 25'd16777;
        track_q   = {FX_ZERO, FX_ZERO, FX_ZERO, FX_ZERO, FX_ONE};

        // A step straight out of reset, then loads and steps at the extremes.
        plan_item(FUNC_STEP, FX_MIN, FX_MAX, FX_MIN, 0, '0);
        plan_item(FUNC_LOAD, FX_MAX, FX_MIN, FX_MAX, 1,
                  {FX_MAX, FX_ZERO, FX_MIN, FX_ZERO, FX_MAX});
        plan_item(FUNC_STEP, FX_MAX, FX_MAX, FX_MAX, 0, '0);
        plan_item(FUNC_STEP, FX_ZERO, FX_ZERO, FX_ZERO, 0, '0);
        plan_item(FUNC_LOAD, FX_MIN, FX_MAX, FX_MIN, 1,
                  {FX_MIN, FX_ZERO, FX_MAX, FX_ZERO, FX_MIN});
        // The drive sits at the most negative value, so negating it saturates.
        plan_item(FUNC_STEP, FX_ZERO, FX_ZERO, FX_ZERO, 0, '0);
        plan_item(FUNC_LOAD, FX_ONE, FX_HALF, FX_QUARTER, 1,
                  {FX_ONE, FX_ZERO, FX_HALF, FX_ZERO, FX_QUARTER});
        plan_item(FUNC_STEP, FX_ZERO, FX_ZERO, FX_ZERO, 0, '0);
        // With a zero step the state must come back untouched.
        plan_write(CFG_STEP_SIZE, 32'd0);
        plan_item(FUNC_LOAD, FX_ONE, FX_HALF, FX_QUARTER, 1,
                  {FX_ONE, FX_ZERO, FX_HALF, FX_ZERO, FX_QUARTER});
        plan_item(FUNC_STEP, FX_ZERO, FX_ZERO, FX_ZERO, 1,
                  {FX_ONE, FX_ZERO, FX_HALF, FX_ZERO, FX_QUARTER});
        // All ones: the bits above the step width must be dropped.
        plan_write(CFG_STEP_SIZE, 32'hFFFF_FFFF);
        plan_item(FUNC_STEP, FX_ZERO, FX_ZERO, FX_ZERO, 0, '0);
        plan_write(CFG_STEP_SIZE, 32'd1);
        plan_item(FUNC_STEP, FX_ZERO, FX_ZERO, FX_ZERO, 0, '0);
        plan_write(CFG_NONE, 32'h1234_5678);
        plan_item(FUNC_STEP, FX_ZERO, FX_ZERO, FX_ZERO, 0, '0);
        plan_write(CFG_STEP_SIZE, FX_ONE);
        plan_write(CFG_GAIN_A1, FX_MAX);
        plan_write(CFG_GAIN_B1, FX_MIN);
        plan_write(CFG_TARGET_G1, FX_MIN);
        plan_write(CFG_GAIN_A2, FX_MIN);
        plan_write(CFG_GAIN_B2, FX_MAX);
        plan_write(CFG_TARGET_G2, FX_MAX);
        plan_item(FUNC_LOAD, FX_ZERO, FX_ZERO, FX_ZERO, 1,
                  {FX_ZERO, FX_ZERO, FX_ZERO, FX_ZERO, FX_ZERO});
        plan_item(FUNC_STEP, FX_ZERO, FX_ZERO, FX_ZERO, 0, '0);
        plan_item(FUNC_STEP, FX_ZERO, FX_ZERO, FX_ZERO, 0, '0);

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_CFG)
                write_reg(plan[i].addr, plan[i].wdata);
            else
                offer(plan[i].func, plan[i].y1, plan[i].y2, plan[i].x,
                      plan[i].known, plan[i].want);
        end

        // Random phases: fresh settings, then an item that is usually a load, followed mostly by steps.
        items_sent = 0;
        phase      = 0;
        while (items_sent < RANDOM_ITEMS) begin
            s_tvalid = 1'b0;
            write_reg(CFG_GAIN_A1, draw_gain());
            write_reg(CFG_GAIN_B1, draw_gain());
            write_reg(CFG_TARGET_G1, draw_gain());
            write_reg(CFG_GAIN_A2, draw_gain());
            write_reg(CFG_GAIN_B2, draw_gain());
            write_reg(CFG_TARGET_G2, draw_gain());
            write_reg(CFG_STEP_SIZE, draw_step());
            no_idle = ($urandom_range(0, 4) == 0);
            if (phase == 1)
                hold_req = 1'b1;
            len = $urandom_range(40, 120);
            for (int n = 0; n < len; n++) begin
                is_load = (n == 0) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 14) == 0);
                if (is_load)
                    offer(FUNC_LOAD, draw_level(), draw_level(), draw_level(), 0, '0);
                else
                    offer(FUNC_STEP, $urandom, $urandom, $urandom, 0, '0);
                items_sent++;
            end
            phase++;
        end
        s_tvalid = 1'b0;
        no_idle  = 1'b0;

        while (pending_states.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        if (mismatches == 0 && pending_states.size() == 0)
            $display("midpoint_rk2_coupled_tracker_core regression: pass");
        else
            $display("midpoint_rk2_coupled_tracker_core regression: fail");
        $finish;
    end

endmodule

// ----- midpoint_rk2_coupled_tracker_core.f -----
rtl/mrk_pkg.sv
rtl/mrk_alu.sv
rtl/mrk_seq.sv
rtl/midpoint_rk2_coupled_tracker_core.sv
tb/tb_midpoint_rk2_coupled_tracker_core.sv
